### rtl/lruc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared sizes, action codes, types and helpers of the timestamp LRU cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int ENTRIES    = 128;
    localparam int KEY_BITS   = 16;
    localparam int STAMP_BITS = 32;

    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int RAM_W      = KEY_BITS + STAMP_BITS;

    localparam int ACT_W      = 2;
    localparam int IN_KEY_W   = 16;
    localparam int SLOT_W     = 7;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INVAL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [SLOT_W-1:0]     t_slot;

    localparam t_stamp STAMP_MAX  = '1;
    localparam t_idx   IDX_LAST   = t_idx'(ENTRIES - 1);

    typedef struct packed {
        logic start;
        logic scan;
        logic write;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic act_scan;
        logic scan_done;
        logic out_free;
    } t_sts;

    function automatic t_key fit_key(input logic [IN_KEY_W-1:0] k);
        logic [IN_KEY_W+KEY_BITS-1:0] ext;
        ext = (IN_KEY_W + KEY_BITS)'(k);
        return ext[KEY_BITS-1:0];
    endfunction

    function automatic t_slot to_slot(input t_idx idx);
        logic [SLOT_W+IDX_W-1:0] ext;
        ext = (SLOT_W + IDX_W)'(idx);
        return ext[SLOT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/lruc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/lruc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_ctrl
// Sequencer: accept a beat, scan+update for lookup/inval, hand off the result.
// ----------------------------------------------------------------------------
module lruc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lruc_pkg::t_sts i_sts,
    output lruc_pkg::t_cmd     o_cmd
);
    import lruc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = i_sts.act_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.write = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

### rtl/lruc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_dpath
// Entry store, valid bits, use counter, scan compare and result register.
// ----------------------------------------------------------------------------
module lruc_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lruc_pkg::t_cmd                      i_cmd,
    output lruc_pkg::t_sts                           o_sts,
    input  wire logic [lruc_pkg::ACT_W-1:0]          i_in_action,
    input  wire logic [lruc_pkg::IN_KEY_W-1:0]       i_in_key,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [lruc_pkg::SLOT_W-1:0]         o_out_slot,
    output logic                                     o_out_hit,
    output logic                                     o_out_refill
);
    import lruc_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    t_stamp             r_counter;
    logic [ACT_W-1:0]   r_op;
    t_key               r_key;

    t_idx               r_rd_idx;
    logic               r_all_issued;
    logic               r_rd_vld;
    t_idx               r_cmp_idx;
    logic               r_found;
    t_idx               r_hit_idx;
    t_idx               r_victim;
    t_stamp             r_best;

    t_slot              r_res_slot;
    logic               r_res_hit;
    logic               r_res_refill;

    logic               r_out_valid;
    t_slot              r_out_slot;
    logic               r_out_hit;
    logic               r_out_refill;

    logic [RAM_W-1:0]   rd_data;
    t_key               rd_key;
    t_stamp             rd_stamp;
    t_stamp             stamp_eff;
    logic               match;
    logic               issue;
    logic               wr_en;
    t_idx               wr_addr;
    logic               wrap;
    t_stamp             next_count;

    assign rd_key    = rd_data[RAM_W-1 -: KEY_BITS];
    assign rd_stamp  = rd_data[STAMP_BITS-1:0];
    assign stamp_eff = r_valid[r_cmp_idx] ? rd_stamp : '0;
    assign match     = r_rd_vld && !r_found && r_valid[r_cmp_idx] && (rd_key == r_key);
    assign issue     = i_cmd.scan && !r_found && !r_all_issued && !match;

    assign wrap       = (r_counter == STAMP_MAX);
    assign next_count = wrap ? t_stamp'(1) : r_counter + t_stamp'(1);

    assign wr_en   = i_cmd.write && (r_op == ACT_LOOKUP);
    assign wr_addr = r_found ? r_hit_idx : r_victim;

    lruc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_key, r_counter}),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_counter    <= '0;
            r_rd_vld     <= 1'b0;
            r_all_issued <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_rd_vld     <= 1'b0;
                r_all_issued <= 1'b0;
                r_found      <= 1'b0;
                if (i_in_action == ACT_CLEAR) begin
                    r_valid   <= '0;
                    r_counter <= '0;
                end else if (i_in_action == ACT_LOOKUP) begin
                    r_counter <= next_count;
                    if (wrap) begin
                        r_valid <= '0;
                    end
                end
            end else begin
                r_rd_vld <= issue;
                if (issue && (r_rd_idx == IDX_LAST)) begin
                    r_all_issued <= 1'b1;
                end
                if (match) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.write) begin
                if (r_op == ACT_LOOKUP) begin
                    r_valid[wr_addr] <= 1'b1;
                end else if (r_found) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op         <= i_in_action;
            r_key        <= fit_key(i_in_key);
            r_rd_idx     <= '0;
            r_victim     <= '0;
            r_best       <= next_count;
            r_res_slot   <= '0;
            r_res_hit    <= 1'b0;
            r_res_refill <= 1'b0;
        end else begin
            if (issue) begin
                r_rd_idx <= r_rd_idx + t_idx'(1);
            end
            r_cmp_idx <= r_rd_idx;
            if (match) begin
                r_hit_idx <= r_cmp_idx;
            end else if (r_rd_vld && !r_found && (stamp_eff < r_best)) begin
                r_best   <= stamp_eff;
                r_victim <= r_cmp_idx;
            end
        end
        if (i_cmd.write) begin
            if (r_op == ACT_LOOKUP) begin
                r_res_slot   <= to_slot(wr_addr);
                r_res_hit    <= r_found;
                r_res_refill <= !r_found;
            end else begin
                r_res_slot   <= r_found ? to_slot(r_hit_idx) : '0;
                r_res_hit    <= r_found;
                r_res_refill <= 1'b0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_slot   <= r_res_slot;
            r_out_hit    <= r_res_hit;
            r_out_refill <= r_res_refill;
        end
    end

    assign o_sts.act_scan  = (i_in_action == ACT_LOOKUP) || (i_in_action == ACT_INVAL);
    assign o_sts.scan_done = r_found || (r_all_issued && !r_rd_vld);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_out_slot   = r_out_slot;
    assign o_out_hit    = r_out_hit;
    assign o_out_refill = r_out_refill;

    a_hit_xor_refill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_refill))
        else $error("hit and refill both set");

    a_counter_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && (i_in_action == ACT_LOOKUP)) |=> (r_counter != '0))
        else $error("use counter zero after lookup");

    a_victim_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write && (r_op == ACT_LOOKUP)) |=> r_valid[$past(wr_addr)])
        else $error("written entry not marked valid");

    a_no_scan_past_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> !issue)
        else $error("read issued after hit");

endmodule
`default_nettype wire

### rtl/lru_timestamp_object_cache_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Lookup and invalidate scan the entry RAM one entry per cycle: up to 128 reads, then
// the read pipe drains, then one update and the hand-off. A hit stops the scan early.
// Clear and unused actions skip the scan and update and go straight to the hand-off.
// One beat is in work at a time; a stalled result holds the next beat in hand-off.
// Synchronous active-low reset empties all entries and zeroes the use counter.
// ----------------------------------------------------------------------------
// lru_timestamp_object_cache_unit
// Fully associative cache with LRU replacement by per-entry use stamps.
// ----------------------------------------------------------------------------
module lru_timestamp_object_cache_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [lruc_pkg::ACT_W-1:0]    i_in_action,
    input  wire logic [lruc_pkg::IN_KEY_W-1:0] i_in_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [lruc_pkg::SLOT_W-1:0]   o_out_slot,
    output logic                               o_out_hit,
    output logic                               o_out_refill
);
    import lruc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lruc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lruc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_action  (i_in_action),
        .i_in_key     (i_in_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_slot   (o_out_slot),
        .o_out_hit    (o_out_hit),
        .o_out_refill (o_out_refill)
    );

endmodule
`default_nettype wire
